// File: hw/rtl/mqrb_pkg.sv
package mqrb_pkg;

   // Defaults for the top-level parameters
   localparam int QUEUE_COUNT_DEFAULT     = 4;
   localparam int SLOTS_PER_QUEUE_DEFAULT = 4;

   // Field widths
   localparam int ACTION_W  = 1;
   localparam int QUEUE_W   = 2;
   localparam int PAYLOAD_W = 32;
   localparam int TICKET_W  = 16;
   localparam int STATUS_W  = 2;
   localparam int RING_W    = 3;
   localparam int SLOT_W    = TICKET_W + PAYLOAD_W;

   localparam logic [RING_W-1:0] RING_LENGTH_RESET = 3'd3;

   typedef enum logic [ACTION_W-1:0] {
      ACT_ENQUEUE = 1'b0,
      ACT_DEQUEUE = 1'b1
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_DONE  = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

endpackage

// File: hw/rtl/mqrb_ram.sv
module mqrb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/multi_queue_ring_buffer.sv
// Multi-queue ring buffer: QUEUE_COUNT circular FIFOs share one slot RAM of
// QUEUE_COUNT * SLOTS_PER_QUEUE entries, each entry a 16-bit ticket and a
// 32-bit payload. Issue an item by raising start; busy is always low, so an
// item is taken at every clock edge where start is high, one per cycle with
// no gaps. Each item gives exactly one result, strobed by rsp_valid for the
// one cycle that begins at the edge after the one that took the item;
// results come in item order. The receiver cannot stall: a result not
// captured in its strobe cycle is gone. One item per cycle holds because
// the pointer, flag and ticket update for the addressed queue is a
// combinational read-modify-write of its registers, and the slot RAM does
// either the enqueue write or the dequeue read of that same cycle.
// Write ring_length (csr_data) only while no item is in flight;
// changing it while queues hold entries can make a dequeue reach a slot that
// was never written, whose ticket and payload are then undefined.
module multi_queue_ring_buffer #(
   parameter int QUEUE_COUNT     = mqrb_pkg::QUEUE_COUNT_DEFAULT,
   parameter int SLOTS_PER_QUEUE = mqrb_pkg::SLOTS_PER_QUEUE_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,

   // Item channel
   input  logic                           start,
   output logic                           busy,
   input  logic [mqrb_pkg::ACTION_W-1:0]  req_action,
   input  logic [mqrb_pkg::QUEUE_W-1:0]   req_queue_id,
   input  logic [mqrb_pkg::PAYLOAD_W-1:0] req_payload_tag,

   // Result channel
   output logic                           rsp_valid,
   output logic [mqrb_pkg::STATUS_W-1:0]  rsp_status,
   output logic [mqrb_pkg::TICKET_W-1:0]  rsp_ticket_number,
   output logic [mqrb_pkg::PAYLOAD_W-1:0] rsp_out_payload,
   output logic                           rsp_queue_full,
   output logic                           rsp_queue_empty,
   output logic                           rsp_all_empty,

   // Ring length register
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [mqrb_pkg::RING_W-1:0]    csr_data
);

   localparam int PTR_W  = (SLOTS_PER_QUEUE > 1) ? $clog2(SLOTS_PER_QUEUE) : 1;
   localparam int QID_W  = (QUEUE_COUNT > 1) ? $clog2(QUEUE_COUNT) : 1;
   localparam int DEPTH  = QUEUE_COUNT * SLOTS_PER_QUEUE;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   // Wide enough for the ring register and for SLOTS_PER_QUEUE itself
   localparam int LEN_W  = ($clog2(SLOTS_PER_QUEUE + 1) > mqrb_pkg::RING_W) ?
                           $clog2(SLOTS_PER_QUEUE + 1) : mqrb_pkg::RING_W;

   // ---------------------------------------------------------------------
   // Configuration: always ready; unenforced rule: written only while idle
   // ---------------------------------------------------------------------
   logic [mqrb_pkg::RING_W-1:0] ring_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         ring_ff <= mqrb_pkg::RING_LENGTH_RESET;
      end else if (csr_valid && csr_ready) begin
         ring_ff <= csr_data;
      end
   end

   // Clamp ring length into 1..SLOTS_PER_QUEUE
   logic [LEN_W-1:0] ring_ext;
   logic [LEN_W-1:0] eff_len;

   always_comb begin
      ring_ext = LEN_W'(ring_ff);
      if (ring_ext == '0) begin
         eff_len = LEN_W'(1);
      end else if (ring_ext > LEN_W'(SLOTS_PER_QUEUE)) begin
         eff_len = LEN_W'(SLOTS_PER_QUEUE);
      end else begin
         eff_len = ring_ext;
      end
   end

   // Step a pointer, wrapping to zero at the effective length
   function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] ptr,
                                                input logic [LEN_W-1:0] len);
      logic [LEN_W-1:0] nxt;
      nxt = LEN_W'(ptr) + LEN_W'(1);
      return (nxt >= len) ? '0 : PTR_W'(nxt);
   endfunction

   // ---------------------------------------------------------------------
   // Input register: take an item every cycle
   // ---------------------------------------------------------------------
   logic                           req_valid_ff;
   mqrb_pkg::action_type           req_action_ff;
   logic [mqrb_pkg::QUEUE_W-1:0]   req_queue_ff;
   logic [mqrb_pkg::PAYLOAD_W-1:0] req_payload_ff;

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= start && !busy;
      end
   end

   always_ff @(posedge clock) begin
      if (start && !busy) begin
         req_action_ff  <= mqrb_pkg::action_type'(req_action);
         req_queue_ff   <= req_queue_id;
         req_payload_ff <= req_payload_tag;
      end
   end

   // ---------------------------------------------------------------------
   // Per-queue state
   // ---------------------------------------------------------------------
   logic [PTR_W-1:0]              head_ff   [QUEUE_COUNT];
   logic [PTR_W-1:0]              head_in   [QUEUE_COUNT];
   logic [PTR_W-1:0]              tail_ff   [QUEUE_COUNT];
   logic [PTR_W-1:0]              tail_in   [QUEUE_COUNT];
   logic [mqrb_pkg::TICKET_W-1:0] ticket_ff [QUEUE_COUNT];
   logic [mqrb_pkg::TICKET_W-1:0] ticket_in [QUEUE_COUNT];
   logic [QUEUE_COUNT-1:0]        q_full_ff;
   logic [QUEUE_COUNT-1:0]        q_full_in;
   logic [QUEUE_COUNT-1:0]        q_empty_ff;
   logic [QUEUE_COUNT-1:0]        q_empty_in;

   // Result stage next values
   mqrb_pkg::status_type          rsp_status_in;
   logic [mqrb_pkg::TICKET_W-1:0] rsp_ticket_in;
   logic                          rsp_deq_in;
   logic                          rsp_full_in;
   logic                          rsp_empty_in;
   logic                          rsp_all_empty_in;

   // Slot RAM access
   logic                          ram_wr_en;
   logic                          ram_rd_en;
   logic [ADDR_W-1:0]             ram_wr_addr;
   logic [ADDR_W-1:0]             ram_rd_addr;
   logic [mqrb_pkg::SLOT_W-1:0]   ram_wr_data;
   logic [mqrb_pkg::SLOT_W-1:0]   ram_rd_data;

   logic                          q_ok;
   logic [QID_W-1:0]              q_idx;
   logic [PTR_W-1:0]              ptr_next;

   always_comb begin
      head_in    = head_ff;
      tail_in    = tail_ff;
      ticket_in  = ticket_ff;
      q_full_in  = q_full_ff;
      q_empty_in = q_empty_ff;

      q_ok  = 32'(req_queue_ff) < QUEUE_COUNT;
      q_idx = QID_W'(req_queue_ff);
      ptr_next = '0;

      // Reject by default; out-of-range queues report empty and not full
      rsp_status_in = (req_action_ff == mqrb_pkg::ACT_DEQUEUE) ?
                      mqrb_pkg::ST_EMPTY : mqrb_pkg::ST_FULL;
      rsp_ticket_in = '0;
      rsp_deq_in    = 1'b0;
      rsp_full_in   = 1'b0;
      rsp_empty_in  = 1'b1;

      ram_wr_en   = 1'b0;
      ram_rd_en   = 1'b0;
      ram_wr_addr = ADDR_W'(32'(q_idx) * SLOTS_PER_QUEUE + 32'(tail_ff[q_idx]));
      ram_rd_addr = ADDR_W'(32'(q_idx) * SLOTS_PER_QUEUE + 32'(head_ff[q_idx]));
      ram_wr_data = {ticket_ff[q_idx], req_payload_ff};

      if (req_valid_ff && q_ok) begin
         if (req_action_ff == mqrb_pkg::ACT_ENQUEUE) begin
            if (!q_full_ff[q_idx]) begin
               // Store at tail, stamp with the running ticket, advance tail
               ptr_next           = advance(tail_ff[q_idx], eff_len);
               ram_wr_en          = 1'b1;
               rsp_ticket_in      = ticket_ff[q_idx];
               ticket_in[q_idx]   = ticket_ff[q_idx] + mqrb_pkg::TICKET_W'(1);
               tail_in[q_idx]     = ptr_next;
               q_empty_in[q_idx]  = 1'b0;
               q_full_in[q_idx]   = (ptr_next == head_ff[q_idx]);
               rsp_status_in      = mqrb_pkg::ST_DONE;
            end
         end else begin
            if (!q_empty_ff[q_idx]) begin
               // Read at head, advance head; ticket and payload come from RAM
               ptr_next           = advance(head_ff[q_idx], eff_len);
               ram_rd_en          = 1'b1;
               rsp_deq_in         = 1'b1;
               head_in[q_idx]     = ptr_next;
               q_full_in[q_idx]   = 1'b0;
               q_empty_in[q_idx]  = (ptr_next == tail_ff[q_idx]);
               rsp_status_in      = mqrb_pkg::ST_DONE;
            end
         end
         rsp_full_in  = q_full_in[q_idx];
         rsp_empty_in = q_empty_in[q_idx];
      end

      rsp_all_empty_in = &q_empty_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int q = 0; q < QUEUE_COUNT; q++) begin
            head_ff[q]   <= '0;
            tail_ff[q]   <= '0;
            ticket_ff[q] <= '0;
         end
         q_full_ff  <= '0;
         q_empty_ff <= '1;
      end else begin
         head_ff    <= head_in;
         tail_ff    <= tail_in;
         ticket_ff  <= ticket_in;
         q_full_ff  <= q_full_in;
         q_empty_ff <= q_empty_in;
      end
   end

   mqrb_ram #(
      .WIDTH (mqrb_pkg::SLOT_W),
      .DEPTH (DEPTH)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // ---------------------------------------------------------------------
   // Result register; dequeue data joins from the RAM read register
   // ---------------------------------------------------------------------
   logic                          rsp_valid_ff;
   mqrb_pkg::status_type          rsp_status_ff;
   logic [mqrb_pkg::TICKET_W-1:0] rsp_ticket_ff;
   logic                          rsp_deq_ff;
   logic                          rsp_full_ff;
   logic                          rsp_empty_ff;
   logic                          rsp_all_empty_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= req_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff    <= rsp_status_in;
      rsp_ticket_ff    <= rsp_ticket_in;
      rsp_deq_ff       <= rsp_deq_in;
      rsp_full_ff      <= rsp_full_in;
      rsp_empty_ff     <= rsp_empty_in;
      rsp_all_empty_ff <= rsp_all_empty_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_ticket_number = rsp_deq_ff ?
                              ram_rd_data[mqrb_pkg::SLOT_W-1:mqrb_pkg::PAYLOAD_W] :
                              rsp_ticket_ff;
   assign rsp_out_payload   = rsp_deq_ff ? ram_rd_data[mqrb_pkg::PAYLOAD_W-1:0] : '0;
   assign rsp_queue_full    = rsp_full_ff;
   assign rsp_queue_empty   = rsp_empty_ff;
   assign rsp_all_empty     = rsp_all_empty_ff;

endmodule
